// ===== design/coordinate_to_csr_converter_macros.svh =====
// assertion macros for the coordinate to csr converter
// depends on nothing; included by the files that carry assertions
`ifndef COORDINATE_TO_CSR_CONVERTER_MACROS_SVH
`define COORDINATE_TO_CSR_CONVERTER_MACROS_SVH

// same-cycle implication, disabled while in reset
`define C2CSR_ASSERT_IMPLY(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> cons) \
      else $error(msg);

// next-cycle implication, disabled while in reset
`define C2CSR_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> cons) \
      else $error(msg);

`endif

// ===== design/c2csr_pkg.sv =====
// shared constants, codes and entry layouts of the coordinate to csr converter
// depends on nothing
package c2csr_pkg;

   localparam int MAX_ROWS    = 1024;
   localparam int MAX_ENTRIES = 4096;

   // request and response field widths
   localparam int ROW_W = 10;
   localparam int COL_W = 10;
   localparam int VAL_W = 64;
   localparam int PTR_W = 13;
   localparam int RC_W  = $clog2(MAX_ROWS + 1);

   // internal widths
   localparam int ROW_AW = $clog2(MAX_ROWS);
   localparam int ENT_AW = $clog2(MAX_ENTRIES);
   localparam int CNT_W  = $clog2(MAX_ENTRIES + 1);
   localparam int IDX_W  = $clog2(MAX_ROWS + MAX_ENTRIES + 1);

   typedef enum logic {
      CMD_LOAD  = 1'b0,
      CMD_FETCH = 1'b1
   } cmd_type;

   typedef enum logic [1:0] {
      STATUS_OK        = 2'd0,
      STATUS_NOT_READY = 2'd1,
      STATUS_ERROR     = 2'd2
   } status_type;

   typedef enum logic {
      KIND_POINTER = 1'b0,
      KIND_ENTRY   = 1'b1
   } kind_type;

   typedef struct packed {
      logic [ROW_W-1:0] row;
      logic [COL_W-1:0] column;
      logic [VAL_W-1:0] value;
   } loaded_entry_type;

   typedef struct packed {
      logic [COL_W-1:0] column;
      logic [VAL_W-1:0] value;
   } csr_entry_type;

endpackage

// ===== design/c2csr_ram.sv =====
// generic simple dual-port ram, one write port and one registered read port
// depends on nothing
module c2csr_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // read returns the old contents when the same entry is written
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== design/coordinate_to_csr_converter.sv =====
// top level of the coordinate to csr converter: sequencer, count and entry memories
// depends on c2csr_pkg, c2csr_ram and coordinate_to_csr_converter_macros.svh
//
// Usage:
//   req_* carries one request: a load (row, column, value, last_entry) or a fetch.
//   A load returns nothing; a fetch returns one rsp_* item. csr_* writes row_count,
//   always ready; write it only while the block is idle.
//   A load does a read-modify-write of the per-row count memory, or none when the
//   entry is dropped for a bad row or a full store.
//   A load with last_entry starts conversion: a prefix pass over the count memory,
//   then a scatter, one entry a cycle, forwarding the count of the row just written.
//   A fetch of a converted matrix reads the count or csr memory, so its response
//   passes the memory read register and then the output register; no new fetch is
//   taken until that answer is registered. A fetch while loading or after the
//   readout is done answers not-ready straight into the output register.
//   Reset starts a clearing pass over the MAX_ROWS entries of the count memory; the
//   first load after a conversion waits for the same pass. Requests are held off
//   meanwhile, csr writes are still taken.
//   A stalled response sits in the output register; loads are still taken, a
//   fetch waits until the output register is free.
`include "coordinate_to_csr_converter_macros.svh"

module coordinate_to_csr_converter
   import c2csr_pkg::*;
(
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_ready,
   input  logic             req_command,
   input  logic [ROW_W-1:0] req_row,
   input  logic [COL_W-1:0] req_column,
   input  logic [VAL_W-1:0] req_value,
   input  logic             req_last_entry,
   output logic             rsp_valid,
   input  logic             rsp_ready,
   output logic [1:0]       rsp_status,
   output logic             rsp_kind,
   output logic [PTR_W-1:0] rsp_row_pointer,
   output logic [COL_W-1:0] rsp_out_column,
   output logic [VAL_W-1:0] rsp_out_value,
   output logic             rsp_last,
   input  logic             csr_valid,
   output logic             csr_ready,
   input  logic [RC_W-1:0]  csr_row_count
);

   typedef enum logic [2:0] {
      ST_CLEAR,
      ST_LOAD,
      ST_LOAD_WR,
      ST_PREFIX,
      ST_SCATTER,
      ST_READY,
      ST_FETCH,
      ST_DRAINED
   } state_type;

   // control registers
   state_type         state_ff, state_in;
   logic [RC_W-1:0]   row_count_ff, row_count_in;
   logic [CNT_W-1:0]  entry_total_ff, entry_total_in;
   logic              load_error_ff, load_error_in;
   logic [IDX_W-1:0]  idx_ff, idx_in;
   logic [RC_W-1:0]   walk_ff, walk_in;
   logic              pend_ff, pend_in;
   logic [CNT_W-1:0]  k_ff, k_in;
   logic              s1_vld_ff, s1_vld_in;
   logic              s2_vld_ff, s2_vld_in;
   logic              fwd_vld_ff, fwd_vld_in;
   logic              ld_last_ff, ld_last_in;
   logic              f_last_ff, f_last_in;
   logic              rsp_valid_ff, rsp_valid_in;

   // payload registers
   logic [CNT_W-1:0]  sum_ff, sum_in;
   logic [ROW_AW-1:0] s2_row_ff, s2_row_in;
   logic [COL_W-1:0]  s2_col_ff, s2_col_in;
   logic [VAL_W-1:0]  s2_val_ff, s2_val_in;
   logic [ROW_AW-1:0] fwd_row_ff, fwd_row_in;
   logic [CNT_W-1:0]  fwd_cnt_ff, fwd_cnt_in;
   logic [ROW_AW-1:0] ld_row_ff, ld_row_in;
   kind_type          f_kind_ff, f_kind_in;
   logic              f_zero_ff, f_zero_in;
   logic              f_ent_ok_ff, f_ent_ok_in;
   status_type        rsp_status_ff, rsp_status_in;
   kind_type          rsp_kind_ff, rsp_kind_in;
   logic [PTR_W-1:0]  rsp_ptr_ff, rsp_ptr_in;
   logic [COL_W-1:0]  rsp_col_ff, rsp_col_in;
   logic [VAL_W-1:0]  rsp_val_ff, rsp_val_in;
   logic              rsp_last_ff, rsp_last_in;

   // memory ports
   logic              cnt_wr_en;
   logic [ROW_AW-1:0] cnt_wr_addr;
   logic [CNT_W-1:0]  cnt_wr_data;
   logic [ROW_AW-1:0] cnt_rd_addr;
   logic [CNT_W-1:0]  cnt_rd_data;

   logic              ld_wr_en;
   logic [ENT_AW-1:0] ld_wr_addr;
   loaded_entry_type  ld_wr_data;
   logic [ENT_AW-1:0] ld_rd_addr;
   loaded_entry_type  ld_rd_data;

   logic              csr_wr_en;
   logic [ENT_AW-1:0] csr_wr_addr;
   csr_entry_type     csr_wr_data;
   logic [ENT_AW-1:0] csr_rd_addr;
   csr_entry_type     csr_rd_data;

   // helpers
   logic [RC_W-1:0]   rc;
   logic              fetch_ok;
   logic              accept;
   logic              load_bad;
   logic              scatter_issue;
   logic [CNT_W-1:0]  scatter_pos;
   logic [IDX_W-1:0]  fetch_pos;
   logic              fetch_done;

   // per-row counts, turned into row ends by the prefix and scatter passes
   c2csr_ram #(.WIDTH(CNT_W), .DEPTH(MAX_ROWS)) u_count_ram (
      .clock   (clock),
      .wr_en   (cnt_wr_en),
      .wr_addr (cnt_wr_addr),
      .wr_data (cnt_wr_data),
      .rd_addr (cnt_rd_addr),
      .rd_data (cnt_rd_data)
   );

   // entries in load order
   c2csr_ram #(.WIDTH($bits(loaded_entry_type)), .DEPTH(MAX_ENTRIES)) u_load_ram (
      .clock   (clock),
      .wr_en   (ld_wr_en),
      .wr_addr (ld_wr_addr),
      .wr_data (ld_wr_data),
      .rd_addr (ld_rd_addr),
      .rd_data (ld_rd_data)
   );

   // entries in csr order
   c2csr_ram #(.WIDTH($bits(csr_entry_type)), .DEPTH(MAX_ENTRIES)) u_csr_ram (
      .clock   (clock),
      .wr_en   (csr_wr_en),
      .wr_addr (csr_wr_addr),
      .wr_data (csr_wr_data),
      .rd_addr (csr_rd_addr),
      .rd_data (csr_rd_data)
   );

   // row_count clamped to 1 .. MAX_ROWS
   always_comb begin
      if (row_count_ff == '0) begin
         rc = RC_W'(1);
      end else if (row_count_ff > RC_W'(MAX_ROWS)) begin
         rc = RC_W'(MAX_ROWS);
      end else begin
         rc = row_count_ff;
      end
   end

   // a fetch may only go in when its response slot is free by the time it lands
   assign fetch_ok = !rsp_valid_ff || rsp_ready;

   always_comb begin
      case (state_ff)
         ST_LOAD: begin
            req_ready = (req_command == CMD_LOAD) || fetch_ok;
         end
         ST_READY, ST_DRAINED: begin
            req_ready = (req_command == CMD_FETCH) && fetch_ok;
         end
         default: begin
            req_ready = 1'b0;
         end
      endcase
   end

   assign accept    = req_valid && req_ready;
   assign load_bad  = (RC_W'(req_row) >= rc) || (entry_total_ff >= CNT_W'(MAX_ENTRIES));

   // readout position arithmetic
   assign fetch_pos  = idx_ff - IDX_W'(rc) - IDX_W'(1);
   assign fetch_done = idx_ff >= (IDX_W'(rc) + IDX_W'(entry_total_ff));

   // scatter: the count read in flight may miss the write of the previous cycle
   assign scatter_issue = k_ff != entry_total_ff;
   assign scatter_pos   = (fwd_vld_ff && (fwd_row_ff == s2_row_ff)) ? fwd_cnt_ff : cnt_rd_data;

   always_comb begin
      state_in       = state_ff;
      row_count_in   = row_count_ff;
      entry_total_in = entry_total_ff;
      load_error_in  = load_error_ff;
      idx_in         = idx_ff;
      walk_in        = walk_ff;
      pend_in        = pend_ff;
      k_in           = k_ff;
      s1_vld_in      = 1'b0;
      s2_vld_in      = 1'b0;
      fwd_vld_in     = 1'b0;
      ld_last_in     = ld_last_ff;
      f_last_in      = f_last_ff;
      rsp_valid_in   = rsp_valid_ff && !rsp_ready;

      sum_in      = sum_ff;
      s2_row_in   = s2_row_ff;
      s2_col_in   = s2_col_ff;
      s2_val_in   = s2_val_ff;
      fwd_row_in  = fwd_row_ff;
      fwd_cnt_in  = fwd_cnt_ff;
      ld_row_in   = ld_row_ff;
      f_kind_in   = f_kind_ff;
      f_zero_in   = f_zero_ff;
      f_ent_ok_in = f_ent_ok_ff;
      rsp_status_in = rsp_status_ff;
      rsp_kind_in   = rsp_kind_ff;
      rsp_ptr_in    = rsp_ptr_ff;
      rsp_col_in    = rsp_col_ff;
      rsp_val_in    = rsp_val_ff;
      rsp_last_in   = rsp_last_ff;

      cnt_wr_en   = 1'b0;
      cnt_wr_addr = '0;
      cnt_wr_data = '0;
      cnt_rd_addr = '0;
      ld_wr_en    = 1'b0;
      ld_wr_addr  = '0;
      ld_wr_data  = '{row: req_row, column: req_column, value: req_value};
      ld_rd_addr  = '0;
      csr_wr_en   = 1'b0;
      csr_wr_addr = '0;
      csr_wr_data = '{column: s2_col_ff, value: s2_val_ff};
      csr_rd_addr = '0;

      if (csr_valid) begin
         row_count_in = csr_row_count;
      end

      case (state_ff)
         ST_CLEAR: begin
            // zero one count a cycle
            cnt_wr_en   = 1'b1;
            cnt_wr_addr = walk_ff[ROW_AW-1:0];
            walk_in     = walk_ff + RC_W'(1);
            if (walk_ff == RC_W'(MAX_ROWS - 1)) begin
               state_in = ST_LOAD;
            end
         end

         ST_LOAD: begin
            if (accept && (req_command == CMD_LOAD)) begin
               if (load_bad) begin
                  load_error_in = 1'b1;
                  if (req_last_entry) begin
                     state_in = ST_PREFIX;
                     walk_in  = '0;
                     pend_in  = 1'b0;
                     sum_in   = '0;
                  end
               end else begin
                  ld_wr_en       = 1'b1;
                  ld_wr_addr     = entry_total_ff[ENT_AW-1:0];
                  cnt_rd_addr    = ROW_AW'(req_row);
                  entry_total_in = entry_total_ff + CNT_W'(1);
                  ld_row_in      = ROW_AW'(req_row);
                  ld_last_in     = req_last_entry;
                  state_in       = ST_LOAD_WR;
               end
            end else if (accept) begin
               rsp_valid_in  = 1'b1;
               rsp_status_in = STATUS_NOT_READY;
               rsp_kind_in   = KIND_POINTER;
               rsp_ptr_in    = '0;
               rsp_col_in    = '0;
               rsp_val_in    = '0;
               rsp_last_in   = 1'b0;
            end
         end

         ST_LOAD_WR: begin
            // count write-back, in the cycle after its read
            cnt_wr_en   = 1'b1;
            cnt_wr_addr = ld_row_ff;
            cnt_wr_data = cnt_rd_data + CNT_W'(1);
            if (ld_last_ff) begin
               state_in = ST_PREFIX;
               walk_in  = '0;
               pend_in  = 1'b0;
               sum_in   = '0;
            end else begin
               state_in = ST_LOAD;
            end
         end

         ST_PREFIX: begin
            // read row walk, write the running start of the row before it
            if (walk_ff != RC_W'(MAX_ROWS)) begin
               cnt_rd_addr = walk_ff[ROW_AW-1:0];
               walk_in     = walk_ff + RC_W'(1);
               pend_in     = 1'b1;
            end else begin
               pend_in = 1'b0;
            end
            if (pend_ff) begin
               cnt_wr_en   = 1'b1;
               cnt_wr_addr = ROW_AW'(walk_ff - RC_W'(1));
               cnt_wr_data = sum_ff;
               sum_in      = sum_ff + cnt_rd_data;
               if (walk_ff == RC_W'(MAX_ROWS)) begin
                  state_in = ST_SCATTER;
                  k_in     = '0;
               end
            end
         end

         ST_SCATTER: begin
            if (scatter_issue) begin
               ld_rd_addr = k_ff[ENT_AW-1:0];
               k_in       = k_ff + CNT_W'(1);
               s1_vld_in  = 1'b1;
            end
            if (s1_vld_ff) begin
               cnt_rd_addr = ROW_AW'(ld_rd_data.row);
               s2_row_in   = ROW_AW'(ld_rd_data.row);
               s2_col_in   = ld_rd_data.column;
               s2_val_in   = ld_rd_data.value;
               s2_vld_in   = 1'b1;
            end
            if (s2_vld_ff) begin
               cnt_wr_en   = 1'b1;
               cnt_wr_addr = s2_row_ff;
               cnt_wr_data = scatter_pos + CNT_W'(1);
               csr_wr_en   = 1'b1;
               csr_wr_addr = scatter_pos[ENT_AW-1:0];
               fwd_vld_in  = 1'b1;
               fwd_row_in  = s2_row_ff;
               fwd_cnt_in  = scatter_pos + CNT_W'(1);
            end
            if (!scatter_issue && !s1_vld_ff && !s2_vld_ff) begin
               state_in = ST_READY;
               idx_in   = '0;
            end
         end

         ST_READY: begin
            if (accept) begin
               // pointer i is the end of row i-1, left by the scatter
               cnt_rd_addr = ROW_AW'(idx_ff - IDX_W'(1));
               csr_rd_addr = fetch_pos[ENT_AW-1:0];
               f_kind_in   = (idx_ff <= IDX_W'(rc)) ? KIND_POINTER : KIND_ENTRY;
               f_zero_in   = idx_ff == '0;
               f_ent_ok_in = fetch_pos < IDX_W'(entry_total_ff);
               f_last_in   = fetch_done;
               if (!fetch_done) begin
                  idx_in = idx_ff + IDX_W'(1);
               end
               state_in = ST_FETCH;
            end else if (req_valid && (req_command == CMD_LOAD)) begin
               // new matrix: clear before taking the load
               state_in       = ST_CLEAR;
               walk_in        = '0;
               entry_total_in = '0;
               load_error_in  = 1'b0;
               idx_in         = '0;
            end
         end

         ST_FETCH: begin
            rsp_valid_in  = 1'b1;
            rsp_status_in = load_error_ff ? STATUS_ERROR : STATUS_OK;
            rsp_kind_in   = f_kind_ff;
            rsp_ptr_in    = ((f_kind_ff == KIND_POINTER) && !f_zero_ff) ?
                            PTR_W'(cnt_rd_data) : '0;
            rsp_col_in    = ((f_kind_ff == KIND_ENTRY) && f_ent_ok_ff) ?
                            csr_rd_data.column : '0;
            rsp_val_in    = ((f_kind_ff == KIND_ENTRY) && f_ent_ok_ff) ?
                            csr_rd_data.value : '0;
            rsp_last_in   = f_last_ff;
            state_in      = f_last_ff ? ST_DRAINED : ST_READY;
         end

         ST_DRAINED: begin
            if (accept) begin
               rsp_valid_in  = 1'b1;
               rsp_status_in = STATUS_NOT_READY;
               rsp_kind_in   = KIND_POINTER;
               rsp_ptr_in    = '0;
               rsp_col_in    = '0;
               rsp_val_in    = '0;
               rsp_last_in   = 1'b0;
            end else if (req_valid && (req_command == CMD_LOAD)) begin
               state_in       = ST_CLEAR;
               walk_in        = '0;
               entry_total_in = '0;
               load_error_in  = 1'b0;
               idx_in         = '0;
            end
         end

         default: begin
            state_in = ST_CLEAR;
            walk_in  = '0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      sum_in_unused_guard: begin
      end
      sum_ff        <= sum_in;
      s2_row_ff     <= s2_row_in;
      s2_col_ff     <= s2_col_in;
      s2_val_ff     <= s2_val_in;
      fwd_row_ff    <= fwd_row_in;
      fwd_cnt_ff    <= fwd_cnt_in;
      ld_row_ff     <= ld_row_in;
      f_kind_ff     <= f_kind_in;
      f_zero_ff     <= f_zero_in;
      f_ent_ok_ff   <= f_ent_ok_in;
      rsp_status_ff <= rsp_status_in;
      rsp_kind_ff   <= rsp_kind_in;
      rsp_ptr_ff    <= rsp_ptr_in;
      rsp_col_ff    <= rsp_col_in;
      rsp_val_ff    <= rsp_val_in;
      rsp_last_ff   <= rsp_last_in;
      if (reset) begin
         state_ff       <= ST_CLEAR;
         row_count_ff   <= RC_W'(MAX_ROWS);
         entry_total_ff <= '0;
         load_error_ff  <= 1'b0;
         idx_ff         <= '0;
         walk_ff        <= '0;
         pend_ff        <= 1'b0;
         k_ff           <= '0;
         s1_vld_ff      <= 1'b0;
         s2_vld_ff      <= 1'b0;
         fwd_vld_ff     <= 1'b0;
         ld_last_ff     <= 1'b0;
         f_last_ff      <= 1'b0;
         rsp_valid_ff   <= 1'b0;
      end else begin
         state_ff       <= state_in;
         row_count_ff   <= row_count_in;
         entry_total_ff <= entry_total_in;
         load_error_ff  <= load_error_in;
         idx_ff         <= idx_in;
         walk_ff        <= walk_in;
         pend_ff        <= pend_in;
         k_ff           <= k_in;
         s1_vld_ff      <= s1_vld_in;
         s2_vld_ff      <= s2_vld_in;
         fwd_vld_ff     <= fwd_vld_in;
         ld_last_ff     <= ld_last_in;
         f_last_ff      <= f_last_in;
         rsp_valid_ff   <= rsp_valid_in;
      end
   end

   assign csr_ready       = 1'b1;
   assign rsp_valid       = rsp_valid_ff;
   assign rsp_status      = rsp_status_ff;
   assign rsp_kind        = rsp_kind_ff;
   assign rsp_row_pointer = rsp_ptr_ff;
   assign rsp_out_column  = rsp_col_ff;
   assign rsp_out_value   = rsp_val_ff;
   assign rsp_last        = rsp_last_ff;

   // store never overfills
   `C2CSR_ASSERT_IMPLY(a_total_bound, clock, reset, 1'b1, (entry_total_ff <= CNT_W'(MAX_ENTRIES)), "entry total above capacity")

   // every scattered entry lands inside the stored range
   `C2CSR_ASSERT_IMPLY(a_scatter_pos, clock, reset, s2_vld_ff, (scatter_pos < entry_total_ff), "scatter position out of range")

   // a fetch only goes in when its response slot will be free
   `C2CSR_ASSERT_IMPLY(a_fetch_slot, clock, reset, (accept && (req_command == CMD_FETCH)), (!rsp_valid_ff || rsp_ready), "fetch taken with output slot busy")

   // a fetch of a converted matrix is answered through ST_FETCH and the output register
   `C2CSR_ASSERT_NEXT(a_fetch_resp, clock, reset, ((state_ff == ST_READY) && accept), ##1 rsp_valid_ff, "fetch response missing")

endmodule

// ===== test/csr_readout_checker.sv =====
`timescale 1ns / 100ps
// checker for the coordinate to csr converter: follows requests and csr writes,
// predicts every fetch answer and compares it with the rsp channel
// depends on c2csr_pkg
module csr_readout_checker
   import c2csr_pkg::*;
(
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   input  logic             req_ready,
   input  logic             req_command,
   input  logic [ROW_W-1:0] req_row,
   input  logic [COL_W-1:0] req_column,
   input  logic [VAL_W-1:0] req_value,
   input  logic             req_last_entry,
   input  logic             rsp_valid,
   input  logic             rsp_ready,
   input  logic [1:0]       rsp_status,
   input  logic             rsp_kind,
   input  logic [PTR_W-1:0] rsp_row_pointer,
   input  logic [COL_W-1:0] rsp_out_column,
   input  logic [VAL_W-1:0] rsp_out_value,
   input  logic             rsp_last,
   input  logic             csr_valid,
   input  logic             csr_ready,
   input  logic [RC_W-1:0]  csr_row_count,
   output int               mismatch_count,
   output int               answers_pending
);

   localparam int PRINT_LIMIT = 40;

   typedef enum logic [1:0] {
      MATRIX_LOADING,
      MATRIX_READY,
      MATRIX_DRAINED
   } matrix_phase_type;

   typedef struct {
      status_type       status;
      kind_type         kind;
      logic [PTR_W-1:0] pointer;
      logic [COL_W-1:0] column;
      logic [VAL_W-1:0] value;
      logic             last;
   } fetch_answer_type;

   // per-row tallies, later row start offsets
   int unsigned      row_offset  [0:MAX_ROWS];
   logic [ROW_W-1:0] held_row    [0:MAX_ENTRIES-1];
   logic [COL_W-1:0] held_column [0:MAX_ENTRIES-1];
   logic [VAL_W-1:0] held_value  [0:MAX_ENTRIES-1];
   logic [COL_W-1:0] csr_column  [0:MAX_ENTRIES-1];
   logic [VAL_W-1:0] csr_value   [0:MAX_ENTRIES-1];
   int unsigned      stored_total;
   int unsigned      read_position;
   bit               entry_dropped;
   matrix_phase_type matrix_phase;
   logic [RC_W-1:0]  row_count_reg;
   fetch_answer_type awaited_answers[$];
   fetch_answer_type next_answer;
   fetch_answer_type oldest;

   initial begin
      mismatch_count  = 0;
      answers_pending = 0;
   end

   function automatic int unsigned rows_in_force();
      if (row_count_reg == 0) return 1;
      if (row_count_reg > MAX_ROWS) return MAX_ROWS;
      return row_count_reg;
   endfunction

   task automatic clear_matrix();
      foreach (row_offset[i]) row_offset[i] = 0;
      stored_total  = 0;
      read_position = 0;
      entry_dropped = 1'b0;
      matrix_phase  = MATRIX_LOADING;
   endtask

   // exclusive prefix sum, stable scatter by row, then shift ends back to starts
   task automatic convert_matrix();
      int unsigned running;
      int unsigned tally;
      int unsigned slot;
      int unsigned i;
      int unsigned k;
      running = 0;
      for (i = 0; i <= MAX_ROWS; i++) begin
         tally         = row_offset[i];
         row_offset[i] = running;
         running      += tally;
      end
      for (k = 0; k < stored_total; k++) begin
         slot                     = row_offset[held_row[k]];
         csr_column[slot]         = held_column[k];
         csr_value[slot]          = held_value[k];
         row_offset[held_row[k]] = slot + 1;
      end
      for (i = MAX_ROWS; i > 0; i--) row_offset[i] = row_offset[i-1];
      row_offset[0] = 0;
      read_position = 0;
      matrix_phase  = MATRIX_READY;
   endtask

   task automatic take_load(input logic [ROW_W-1:0] row, input logic [COL_W-1:0] column,
                            input logic [VAL_W-1:0] value, input logic last_mark);
      if (matrix_phase != MATRIX_LOADING) clear_matrix();
      if (row >= rows_in_force() || stored_total >= MAX_ENTRIES) begin
         entry_dropped = 1'b1;
      end else begin
         held_row[stored_total]    = row;
         held_column[stored_total] = column;
         held_value[stored_total]  = value;
         row_offset[row]++;
         stored_total++;
      end
      if (last_mark) convert_matrix();
   endtask

   task automatic take_fetch(output fetch_answer_type answer);
      int unsigned rows;
      int unsigned position;
      rows           = rows_in_force();
      answer.status  = STATUS_NOT_READY;
      answer.kind    = KIND_POINTER;
      answer.pointer = '0;
      answer.column  = '0;
      answer.value   = '0;
      answer.last    = 1'b0;
      if (matrix_phase != MATRIX_READY) return;
      answer.status = entry_dropped ? STATUS_ERROR : STATUS_OK;
      if (read_position <= rows) begin
         answer.pointer = PTR_W'(row_offset[read_position]);
      end else begin
         position    = read_position - rows - 1;
         answer.kind = KIND_ENTRY;
         if (position < stored_total) begin
            answer.column = csr_column[position];
            answer.value  = csr_value[position];
         end
      end
      if (read_position >= rows + stored_total) begin
         answer.last  = 1'b1;
         matrix_phase = MATRIX_DRAINED;
      end else begin
         read_position++;
      end
   endtask

   task automatic report_mismatch(input string what, input logic [VAL_W-1:0] seen,
                                  input logic [VAL_W-1:0] wanted);
      mismatch_count++;
      if (mismatch_count <= PRINT_LIMIT)
         $display("%0t: %s: seen %0h, predicted %0h", $time, what, seen, wanted);
   endtask

   always @(posedge clock) begin
      if (reset) begin
         clear_matrix();
         row_count_reg = RC_W'(MAX_ROWS);
         awaited_answers.delete();
      end else begin
         if (csr_valid && csr_ready) row_count_reg = csr_row_count;
         if (req_valid && req_ready) begin
            if (req_command == CMD_FETCH) begin
               take_fetch(next_answer);
               awaited_answers.push_back(next_answer);
            end else begin
               take_load(req_row, req_column, req_value, req_last_entry);
            end
         end
         if (rsp_valid && rsp_ready) begin
            if (awaited_answers.size() == 0) begin
               report_mismatch("response with no fetch outstanding", rsp_status, '0);
            end else begin
               oldest = awaited_answers.pop_front();
               if (rsp_status !== oldest.status)
                  report_mismatch("status", rsp_status, oldest.status);
               if (rsp_kind !== oldest.kind)
                  report_mismatch("kind", rsp_kind, oldest.kind);
               if (rsp_row_pointer !== oldest.pointer)
                  report_mismatch("row pointer", rsp_row_pointer, oldest.pointer);
               if (rsp_out_column !== oldest.column)
                  report_mismatch("column", rsp_out_column, oldest.column);
               if (rsp_out_value !== oldest.value)
                  report_mismatch("value", rsp_out_value, oldest.value);
               if (rsp_last !== oldest.last)
                  report_mismatch("last", rsp_last, oldest.last);
            end
         end
      end
      answers_pending = awaited_answers.size();
   end

endmodule

// ===== test/tb_coordinate_to_csr_converter.sv =====
`timescale 1ns / 100ps
// testbench top for the coordinate to csr converter: clock, reset, request and csr
// stimulus, receiver back-pressure and the verdict
// depends on c2csr_pkg, coordinate_to_csr_converter and csr_readout_checker
module tb_coordinate_to_csr_converter;
   import c2csr_pkg::*;

   localparam int RANDOM_ITEMS  = 400;
   // prefix pass plus the longest scatter, with some margin
   localparam int SETTLE_CYCLES = MAX_ROWS + MAX_ENTRIES + 16;
   localparam int DRAIN_CYCLES  = 32;
   localparam int LONG_HOLD     = 300;
   localparam int TIMEOUT_NS    = 10_000_000;

   logic             clock          = 1'b0;
   logic             reset          = 1'b1;
   logic             req_valid      = 1'b0;
   logic             req_ready;
   cmd_type          req_command    = CMD_LOAD;
   logic [ROW_W-1:0] req_row        = '0;
   logic [COL_W-1:0] req_column     = '0;
   logic [VAL_W-1:0] req_value      = '0;
   logic             req_last_entry = 1'b0;
   logic             rsp_valid;
   logic             rsp_ready      = 1'b0;
   logic [1:0]       rsp_status;
   logic             rsp_kind;
   logic [PTR_W-1:0] rsp_row_pointer;
   logic [COL_W-1:0] rsp_out_column;
   logic [VAL_W-1:0] rsp_out_value;
   logic             rsp_last;
   logic             csr_valid      = 1'b0;
   logic             csr_ready;
   logic [RC_W-1:0]  csr_row_count  = RC_W'(MAX_ROWS);

   int mismatch_count;
   int answers_pending;

   // idle odds in percent per cycle for each side, and a long receiver hold-off
   int send_idle_pct = 15;
   int recv_idle_pct = 61;
   int hold_left     = 0;

   // bookkeeping of the current matrix, used to size the readouts, count requests and settle
   int              accepted_requests = 0;
   int              tracked_stored    = 0;
   int              tracked_fetched   = 0;
   bit              tracked_converted = 1'b0;
   bit              last_was_load     = 1'b0;
   logic [RC_W-1:0] row_count_now     = RC_W'(MAX_ROWS);

   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   initial begin
      repeat (7) @(posedge clock);
      reset <= 1'b0;
   end

   // receiver: random back-pressure, or a solid hold-off while hold_left runs down
   always @(posedge clock) begin
      if (hold_left > 0) begin
         rsp_ready <= 1'b0;
         hold_left--;
      end else begin
         rsp_ready <= ($urandom_range(99) >= recv_idle_pct);
      end
   end

   coordinate_to_csr_converter u_top (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_ready       (req_ready),
      .req_command     (req_command),
      .req_row         (req_row),
      .req_column      (req_column),
      .req_value       (req_value),
      .req_last_entry  (req_last_entry),
      .rsp_valid       (rsp_valid),
      .rsp_ready       (rsp_ready),
      .rsp_status      (rsp_status),
      .rsp_kind        (rsp_kind),
      .rsp_row_pointer (rsp_row_pointer),
      .rsp_out_column  (rsp_out_column),
      .rsp_out_value   (rsp_out_value),
      .rsp_last        (rsp_last),
      .csr_valid       (csr_valid),
      .csr_ready       (csr_ready),
      .csr_row_count   (csr_row_count)
   );

   csr_readout_checker u_checker (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_ready       (req_ready),
      .req_command     (req_command),
      .req_row         (req_row),
      .req_column      (req_column),
      .req_value       (req_value),
      .req_last_entry  (req_last_entry),
      .rsp_valid       (rsp_valid),
      .rsp_ready       (rsp_ready),
      .rsp_status      (rsp_status),
      .rsp_kind        (rsp_kind),
      .rsp_row_pointer (rsp_row_pointer),
      .rsp_out_column  (rsp_out_column),
      .rsp_out_value   (rsp_out_value),
      .rsp_last        (rsp_last),
      .csr_valid       (csr_valid),
      .csr_ready       (csr_ready),
      .csr_row_count   (csr_row_count),
      .mismatch_count  (mismatch_count),
      .answers_pending (answers_pending)
   );

   function automatic int effective_rows(input logic [RC_W-1:0] setting);
      if (setting == 0) return 1;
      if (setting > MAX_ROWS) return MAX_ROWS;
      return setting;
   endfunction

   function automatic logic [VAL_W-1:0] random_value();
      return {$urandom, $urandom};
   endfunction

   // one request; valid only drops when an idle cycle is drawn, so a
   // back-to-back request keeps valid high across the handshake edge
   task automatic send_request(input cmd_type command, input logic [ROW_W-1:0] row,
                               input logic [COL_W-1:0] column,
                               input logic [VAL_W-1:0] value, input logic last_mark);
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid      <= 1'b1;
      req_command    <= command;
      req_row        <= row;
      req_column     <= column;
      req_value      <= value;
      req_last_entry <= last_mark;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      accepted_requests++;
   endtask

   task automatic load_entry(input logic [ROW_W-1:0] row, input logic [COL_W-1:0] column,
                             input logic [VAL_W-1:0] value, input logic last_mark);
      // a load after conversion opens a fresh matrix
      if (tracked_converted) begin
         tracked_stored    = 0;
         tracked_converted = 1'b0;
      end
      send_request(CMD_LOAD, row, column, value, last_mark);
      if (row < effective_rows(row_count_now) && tracked_stored < MAX_ENTRIES)
         tracked_stored++;
      if (last_mark) begin
         tracked_converted = 1'b1;
         tracked_fetched   = 0;
      end
      last_was_load = 1'b1;
   endtask

   // fetch payload fields are don't-care, so they carry random noise
   task automatic fetch_items(input int count);
      repeat (count) begin
         send_request(CMD_FETCH, ROW_W'($urandom), COL_W'($urandom), random_value(),
                      1'($urandom));
         tracked_fetched++;
         last_was_load = 1'b0;
      end
   endtask

   // fetch what is left of the readout (pointers then entries), plus extra not-ready ones
   task automatic finish_readout(input int extra);
      int remaining;
      remaining = effective_rows(row_count_now) + 1 + tracked_stored - tracked_fetched;
      if (!tracked_converted || remaining < 0) remaining = 0;
      fetch_items(remaining + extra);
   endtask

   // wait until every fetch is answered; after a trailing load, let the conversion finish
   task automatic settle();
      req_valid <= 1'b0;
      @(posedge clock);
      while (answers_pending != 0) @(posedge clock);
      if (last_was_load) repeat (SETTLE_CYCLES) @(posedge clock);
      last_was_load = 1'b0;
   endtask

   task automatic write_row_count(input logic [RC_W-1:0] setting);
      csr_valid     <= 1'b1;
      csr_row_count <= setting;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      csr_valid     <= 1'b0;
      row_count_now  = setting;
   endtask

   // one well-formed matrix with random content, some stray fetches and dropped rows,
   // read out fully or cut short by the next matrix
   task automatic random_matrix();
      int               pick;
      int               rows;
      int               loads;
      int               n;
      logic [ROW_W-1:0] row;
      settle();
      pick = $urandom_range(99);
      if (pick < 80)      write_row_count(RC_W'($urandom_range(12, 1)));
      else if (pick < 95) write_row_count(RC_W'($urandom_range(64, 13)));
      else                write_row_count('0);
      rows = effective_rows(row_count_now);
      if ($urandom_range(99) < 20) fetch_items(1);
      loads = $urandom_range(14, 1);
      for (n = 0; n < loads; n++) begin
         if ($urandom_range(99) < 85) row = ROW_W'($urandom_range(rows - 1, 0));
         else                         row = ROW_W'($urandom_range(1023, 0));
         load_entry(row, COL_W'($urandom), random_value(), n == loads - 1);
         // fetch in the middle of loading answers not-ready
         if (n < loads - 1 && $urandom_range(99) < 8) fetch_items(1);
      end
      if ($urandom_range(99) < 75) finish_readout($urandom_range(2, 0));
      else fetch_items($urandom_range(rows + tracked_stored, 0));
   endtask

   initial begin : stimulus
      int first_random;
      int done;
      int n;
      while (reset) @(posedge clock);

      // fetch with nothing loaded yet
      fetch_items(1);
      settle();
      write_row_count(RC_W'(3));

      // small matrix: field extremes, rows past the end, two entries in one row
      load_entry('0, '0, '0, 1'b0);
      load_entry(ROW_W'(2), '1, '1, 1'b0);
      load_entry(ROW_W'(1), COL_W'(5), random_value(), 1'b0);
      load_entry(ROW_W'(3), COL_W'(7), random_value(), 1'b0);
      load_entry('1, '1, random_value(), 1'b0);
      load_entry('0, COL_W'(9), random_value(), 1'b0);
      load_entry(ROW_W'(2), COL_W'(3), random_value(), 1'b1);
      finish_readout(1);

      // new matrix straight after a drained readout, then shrink row_count mid-readout
      load_entry(ROW_W'(1), COL_W'(2), random_value(), 1'b1);
      fetch_items(2);
      settle();
      write_row_count(RC_W'(1));
      finish_readout(1);

      // row_count 0 behaves as 1; the only entry is dropped but still converts
      settle();
      write_row_count('0);
      load_entry(ROW_W'(5), COL_W'($urandom), random_value(), 1'b1);
      finish_readout(1);

      // full-size matrix, with the receiver held off so the output stalls fetches
      settle();
      write_row_count(RC_W'(MAX_ROWS));
      load_entry('1, COL_W'($urandom), random_value(), 1'b0);
      load_entry('0, COL_W'($urandom), random_value(), 1'b0);
      load_entry(ROW_W'($urandom), COL_W'($urandom), random_value(), 1'b0);
      load_entry('1, COL_W'($urandom), random_value(), 1'b1);
      hold_left = LONG_HOLD;
      finish_readout(0);

      // all-ones row_count clamps to the maximum
      settle();
      write_row_count('1);
      for (n = 0; n < 3; n++)
         load_entry(ROW_W'($urandom), COL_W'($urandom), random_value(), n == 2);
      finish_readout(1);

      // random matrices across three idling regimes
      first_random = accepted_requests;
      done         = 0;
      while (done < RANDOM_ITEMS) begin
         if (done < RANDOM_ITEMS / 3) begin
            send_idle_pct = 15;
            recv_idle_pct = 61;
         end else if (done < 2 * RANDOM_ITEMS / 3) begin
            send_idle_pct = 61;
            recv_idle_pct = 15;
         end else begin
            send_idle_pct = 0;
            recv_idle_pct = 0;
         end
         random_matrix();
         done = accepted_requests - first_random;
      end

      // fill the entry store past capacity; one stray row is dropped on the way
      settle();
      write_row_count(RC_W'(16));
      for (n = 0; n < MAX_ENTRIES + 4; n++) begin
         if (n == 100) load_entry(ROW_W'(700), COL_W'($urandom), random_value(), 1'b0);
         else load_entry(ROW_W'($urandom_range(15, 0)), COL_W'($urandom), random_value(),
                         n == MAX_ENTRIES + 3);
      end
      finish_readout(1);

      settle();
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (mismatch_count == 0) begin
         $display("PASS");
      end else begin
         $display("FAIL");
      end
      $finish;
   end

   initial begin
      #TIMEOUT_NS;
      $display("FAIL");
      $finish;
   end

endmodule

// ===== files.f =====
+incdir+design
design/c2csr_pkg.sv
design/c2csr_ram.sv
design/coordinate_to_csr_converter.sv
test/csr_readout_checker.sv
test/tb_coordinate_to_csr_converter.sv
